// ----- rtl/lac_pkg.sv -----
package lac_pkg;

  localparam int ENTRIES_DEF  = 16;
  localparam int AGE_BITS_DEF = 8;
  localparam int KEY_BITS_DEF = 32;

  localparam int OP_W      = 2;
  localparam int KEY_W     = 32;
  localparam int PAYLOAD_W = 32;
  localparam int LENGTH_W  = 24;

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 2'd0,
    OP_FIND  = 2'd1,
    OP_INVAL = 2'd2
  } op_e;

endpackage

// ----- rtl/lac_if.sv -----
interface lac_req_if import lac_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      op;
  logic [KEY_W-1:0]     key;
  logic [PAYLOAD_W-1:0] payload;
  logic [LENGTH_W-1:0]  length;

  modport source (output valid, op, key, payload, length, input ready);
  modport sink   (input valid, op, key, payload, length, output ready);
endinterface

interface lac_rsp_if import lac_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 found;
  logic                 evicted;
  logic [PAYLOAD_W-1:0] hit_payload;
  logic [LENGTH_W-1:0]  hit_length;

  modport source (output valid, found, evicted, hit_payload, hit_length, input ready);
  modport sink   (input valid, found, evicted, hit_payload, hit_length, output ready);
endinterface

// ----- rtl/lac_cell.sv -----
module lac_cell import lac_pkg::*; #(
  parameter int AGE_BITS = AGE_BITS_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF,
  parameter int IDX_W    = 4,
  localparam int CAND_W  = 3 + 3 * IDX_W + 2 * AGE_BITS + PAYLOAD_W + LENGTH_W,
  localparam int CMD_W   = 6 + 3 * IDX_W + 2 * AGE_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [IDX_W-1:0]     idx_i,
  input  logic [KEY_BITS-1:0]  key_i,
  input  logic [PAYLOAD_W-1:0] payload_i,
  input  logic [LENGTH_W-1:0]  length_i,
  input  logic [CMD_W-1:0]     cmd_i,
  input  logic [CAND_W-1:0]    cand_i,
  output logic [CAND_W-1:0]    cand_o
);

  typedef struct packed {
    logic                 hit;
    logic [IDX_W-1:0]     hit_idx;
    logic [AGE_BITS-1:0]  hit_age;
    logic [PAYLOAD_W-1:0] hit_payload;
    logic [LENGTH_W-1:0]  hit_length;
    logic                 fre;
    logic [IDX_W-1:0]     fre_idx;
    logic                 have_v;
    logic [AGE_BITS-1:0]  best_age;
    logic [IDX_W-1:0]     best_idx;
  } cand_t;

  typedef struct packed {
    logic                clr_en;
    logic [IDX_W-1:0]    clr_idx;
    logic                dec_en;
    logic [AGE_BITS-1:0] dec_age;
    logic                inc_all;
    logic                inc_below;
    logic [AGE_BITS-1:0] below_age;
    logic                zero_en;
    logic [IDX_W-1:0]    zero_idx;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_idx;
  } cmd_t;

  localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

  cmd_t  cmd;
  cand_t cand_in;
  cand_t cand_d, cand_q;

  logic                 valid_d, valid_q;
  logic [AGE_BITS-1:0]  age_d, age_q;
  logic [KEY_BITS-1:0]  tag_q;
  logic [PAYLOAD_W-1:0] payload_q;
  logic [LENGTH_W-1:0]  length_q;

  logic match;
  logic wr_mine;

  assign cmd     = cmd_i;
  assign cand_in = cand_i;
  assign cand_o  = cand_q;

  assign match   = valid_q && (tag_q == key_i);
  assign wr_mine = cmd.wr_en && (cmd.wr_idx == idx_i);

  // fold this slot into the search record coming from the lower slots
  always_comb begin
    cand_d = cand_in;
    if (!cand_in.hit && match) begin
      cand_d.hit         = 1'b1;
      cand_d.hit_idx     = idx_i;
      cand_d.hit_age     = age_q;
      cand_d.hit_payload = payload_q;
      cand_d.hit_length  = length_q;
    end
    // a slot holding the key counts as free for an add
    if (!cand_in.fre && (!valid_q || match)) begin
      cand_d.fre     = 1'b1;
      cand_d.fre_idx = idx_i;
    end
    // strict compare keeps the lowest index on a tie
    if (valid_q && (!cand_in.have_v || age_q > cand_in.best_age)) begin
      cand_d.have_v   = 1'b1;
      cand_d.best_age = age_q;
      cand_d.best_idx = idx_i;
    end
  end

  always_comb begin
    age_d   = age_q;
    valid_d = valid_q;
    if (cmd.dec_en && age_q > cmd.dec_age) begin
      age_d = age_q - 1'b1;
    end
    if (cmd.inc_all && age_d != AGE_MAX) begin
      age_d = age_d + 1'b1;
    end
    if (cmd.inc_below && age_q < cmd.below_age && age_q != AGE_MAX) begin
      age_d = age_q + 1'b1;
    end
    if (cmd.zero_en && cmd.zero_idx == idx_i) begin
      age_d = '0;
    end
    if (cmd.clr_en && cmd.clr_idx == idx_i) begin
      valid_d = 1'b0;
    end
    if (wr_mine) begin
      age_d   = '0;
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      age_q   <= '0;
    end else begin
      valid_q <= valid_d;
      age_q   <= age_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q <= cand_d;
    if (wr_mine) begin
      tag_q     <= key_i;
      payload_q <= payload_i;
      length_q  <= length_i;
    end
  end

endmodule

// ----- rtl/lru_age_counter_cache.sv -----
// fully associative cache with lru replacement kept as per-slot age counters
//
// req_i carries one transaction per request: op (add, find, invalidate),
// key, payload and length. rsp_o returns exactly one transaction per
// request: found, evicted, hit_payload and hit_length, in request order.
// the slots form a chain of cells; a search record walks the chain one
// cell per cycle, collecting the key hit, the lowest free slot and the
// oldest valid slot. an apply step then broadcasts the age and valid update.
// the request is registered, scanned in ST_SCAN while the record walks the
// chain, and applied in ST_APPLY, which loads the response register. a new
// request is not taken while one is in flight; the next request is taken in the
// cycle the previous response is loaded.
// a response waiting in the output register does not block the next
// request; that request scans and then holds before its update until the
// output register is free, so a stalled receiver only delays the update.
// reset clears all valid bits and ages; tag, payload and length hold
// whatever they had until an add writes them.
module lru_age_counter_cache import lac_pkg::*; #(
  parameter int ENTRIES  = ENTRIES_DEF,
  parameter int AGE_BITS = AGE_BITS_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  lac_req_if.sink      req_i,
  lac_rsp_if.source    rsp_o
);

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int CAND_W = 3 + 3 * IDX_W + 2 * AGE_BITS + PAYLOAD_W + LENGTH_W;
  localparam int CMD_W  = 6 + 3 * IDX_W + 2 * AGE_BITS;

  typedef struct packed {
    logic                 hit;
    logic [IDX_W-1:0]     hit_idx;
    logic [AGE_BITS-1:0]  hit_age;
    logic [PAYLOAD_W-1:0] hit_payload;
    logic [LENGTH_W-1:0]  hit_length;
    logic                 fre;
    logic [IDX_W-1:0]     fre_idx;
    logic                 have_v;
    logic [AGE_BITS-1:0]  best_age;
    logic [IDX_W-1:0]     best_idx;
  } cand_t;

  typedef struct packed {
    logic                clr_en;
    logic [IDX_W-1:0]    clr_idx;
    logic                dec_en;
    logic [AGE_BITS-1:0] dec_age;
    logic                inc_all;
    logic                inc_below;
    logic [AGE_BITS-1:0] below_age;
    logic                zero_en;
    logic [IDX_W-1:0]    zero_idx;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_idx;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } state_e;

  state_e               state_q;
  logic [IDX_W-1:0]     cnt_q;
  logic [OP_W-1:0]      op_q;
  logic [KEY_BITS-1:0]  key_q;
  logic [PAYLOAD_W-1:0] payload_q;
  logic [LENGTH_W-1:0]  length_q;

  logic                 rsp_valid_q;
  logic                 found_q, found_d;
  logic                 evicted_q, evicted_d;
  logic [PAYLOAD_W-1:0] hit_payload_q, hit_payload_d;
  logic [LENGTH_W-1:0]  hit_length_q, hit_length_d;

  logic [KEY_BITS-1:0]  req_tag;
  logic [CAND_W-1:0]    link [ENTRIES+1];
  cand_t                res;
  cmd_t                 cmd;
  logic                 fire;
  logic                 accept;

  if (KEY_BITS >= KEY_W) begin : g_key_wide
    assign req_tag = KEY_BITS'(req_i.key);
  end else begin : g_key_narrow
    assign req_tag = req_i.key[KEY_BITS-1:0];
  end

  assign fire        = (state_q == ST_APPLY) && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready = (state_q == ST_IDLE) || fire;
  assign accept      = req_i.valid && req_i.ready;

  assign link[0] = '0;
  assign res     = link[ENTRIES];

  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    lac_cell #(
      .AGE_BITS (AGE_BITS),
      .KEY_BITS (KEY_BITS),
      .IDX_W    (IDX_W)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .idx_i     (IDX_W'(k)),
      .key_i     (key_q),
      .payload_i (payload_q),
      .length_i  (length_q),
      .cmd_i     (cmd),
      .cand_i    (link[k]),
      .cand_o    (link[k+1])
    );
  end

  // turn the finished search record into one update for all cells
  always_comb begin
    cmd           = '0;
    found_d       = 1'b0;
    evicted_d     = 1'b0;
    hit_payload_d = '0;
    hit_length_d  = '0;
    if (fire) begin
      case (op_q)
        OP_ADD: begin
          cmd.inc_all = 1'b1;
          cmd.wr_en   = 1'b1;
          cmd.wr_idx  = res.fre ? res.fre_idx : res.best_idx;
          cmd.clr_en  = res.hit;
          cmd.clr_idx = res.hit_idx;
          // at most one slot is freed: the old copy of the key or the victim
          cmd.dec_en  = res.hit || !res.fre;
          cmd.dec_age = res.hit ? res.hit_age : res.best_age;
          found_d     = 1'b1;
          evicted_d   = !res.fre;
        end
        OP_FIND: begin
          if (res.hit) begin
            cmd.inc_below = 1'b1;
            cmd.below_age = res.hit_age;
            cmd.zero_en   = 1'b1;
            cmd.zero_idx  = res.hit_idx;
            found_d       = 1'b1;
            hit_payload_d = res.hit_payload;
            hit_length_d  = res.hit_length;
          end
        end
        OP_INVAL: begin
          if (res.hit) begin
            cmd.clr_en  = 1'b1;
            cmd.clr_idx = res.hit_idx;
            cmd.dec_en  = 1'b1;
            cmd.dec_age = res.hit_age;
            found_d     = 1'b1;
          end
        end
        default: begin
          found_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cnt_q         <= '0;
      op_q          <= '0;
      key_q         <= '0;
      payload_q     <= '0;
      length_q      <= '0;
      rsp_valid_q   <= 1'b0;
      found_q       <= 1'b0;
      evicted_q     <= 1'b0;
      hit_payload_q <= '0;
      hit_length_q  <= '0;
    end else begin
      if (fire) begin
        rsp_valid_q   <= 1'b1;
        found_q       <= found_d;
        evicted_q     <= evicted_d;
        hit_payload_q <= hit_payload_d;
        hit_length_q  <= hit_length_d;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (cnt_q == IDX_W'(ENTRIES - 1)) begin
            state_q <= ST_APPLY;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_APPLY: begin
          if (fire) begin
            state_q <= accept ? ST_SCAN : ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      if (accept) begin
        cnt_q     <= '0;
        op_q      <= req_i.op;
        key_q     <= req_tag;
        payload_q <= req_i.payload;
        length_q  <= req_i.length;
      end
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.found       = found_q;
  assign rsp_o.evicted     = evicted_q;
  assign rsp_o.hit_payload = hit_payload_q;
  assign rsp_o.hit_length  = hit_length_q;

endmodule

// ----- tb/tb.sv -----
module tb import lac_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_SLOTS  = ENTRIES_DEF;
  localparam int AGE_W    = AGE_BITS_DEF;
  localparam logic [AGE_W-1:0] AGE_TOP = '1;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int KEY_POOL = 24;
  localparam int RAND_PER_PHASE = 160;
  localparam int LONG_STALL = 300;
  localparam int MAX_PRINTS = 100;
  localparam int TIMEOUT_NS = 2_000_000;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] payload;
    logic [LENGTH_W-1:0]  length;
  } cache_req_t;

  typedef struct packed {
    logic                 found;
    logic                 evicted;
    logic [PAYLOAD_W-1:0] hit_payload;
    logic [LENGTH_W-1:0]  hit_length;
  } cache_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  lac_req_if req_if ();
  lac_rsp_if rsp_if ();

  lru_age_counter_cache uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #2 clk_i = ~clk_i;

  // shadow copy of the cache contents
  bit                   c_valid [N_SLOTS];
  logic [KEY_W-1:0]     c_tag   [N_SLOTS];
  logic [PAYLOAD_W-1:0] c_pay   [N_SLOTS];
  logic [LENGTH_W-1:0]  c_len   [N_SLOTS];
  logic [AGE_W-1:0]     c_age   [N_SLOTS];

  cache_req_t pend_q [$];
  cache_rsp_t lookup_q [$];
  logic [KEY_W-1:0] key_pool [KEY_POOL];

  int send_idle_pct = 10;
  int recv_idle_pct = 80;
  bit long_stall_go = 1'b0;
  int stall_cnt = 0;
  bit req_done = 1'b0;

  int err_cnt = 0;
  int n_req = 0;
  int n_rsp = 0;
  int n_evict = 0;
  int n_find_hit = 0;
  int n_inval_hit = 0;

  task automatic flag_error(input string msg);
    if (err_cnt < MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      flag_error($sformatf("%s got %0h expected %0h (result %0d)", name, got, want, n_rsp));
  endtask

  function automatic int slot_of(logic [KEY_W-1:0] key);
    int hit;
    hit = -1;
    for (int s = N_SLOTS - 1; s >= 0; s--)
      if (c_valid[s] && c_tag[s] == key) hit = s;
    return hit;
  endfunction

  // free a slot and close the gap in the age order above it
  function automatic void drop_slot(int s);
    logic [AGE_W-1:0] a;
    a = c_age[s];
    c_valid[s] = 1'b0;
    for (int k = 0; k < N_SLOTS; k++)
      if (c_age[k] > a) c_age[k]--;
  endfunction

  function automatic cache_rsp_t cache_step(cache_req_t r);
    cache_rsp_t res;
    int s;
    int free_s;
    int victim;
    bit have;
    logic [AGE_W-1:0] oldest;
    logic [AGE_W-1:0] a;
    res = '0;
    case (r.op)
      OP_ADD: begin
        s = slot_of(r.key);
        if (s >= 0) drop_slot(s);
        free_s = -1;
        victim = 0;
        have = 1'b0;
        oldest = '0;
        for (int k = 0; k < N_SLOTS; k++) begin
          if (!c_valid[k] && free_s < 0) free_s = k;
          if (c_valid[k] && (!have || c_age[k] > oldest)) begin
            oldest = c_age[k];
            victim = k;
            have = 1'b1;
          end
        end
        if (free_s < 0) begin
          drop_slot(victim);
          free_s = victim;
          res.evicted = 1'b1;
          n_evict++;
        end
        for (int k = 0; k < N_SLOTS; k++)
          if (c_age[k] != AGE_TOP) c_age[k]++;
        c_valid[free_s] = 1'b1;
        c_tag[free_s] = r.key;
        c_pay[free_s] = r.payload;
        c_len[free_s] = r.length;
        c_age[free_s] = '0;
        res.found = 1'b1;
      end
      OP_FIND: begin
        s = slot_of(r.key);
        if (s >= 0) begin
          a = c_age[s];
          for (int k = 0; k < N_SLOTS; k++)
            if (c_age[k] < a && c_age[k] != AGE_TOP) c_age[k]++;
          c_age[s] = '0;
          res.found = 1'b1;
          res.hit_payload = c_pay[s];
          res.hit_length = c_len[s];
          n_find_hit++;
        end
      end
      OP_INVAL: begin
        s = slot_of(r.key);
        if (s >= 0) begin
          drop_slot(s);
          res.found = 1'b1;
          n_inval_hit++;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic cache_req_t make_req(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                          logic [PAYLOAD_W-1:0] payload,
                                          logic [LENGTH_W-1:0] length);
    cache_req_t r;
    r.op = op;
    r.key = key;
    r.payload = payload;
    r.length = length;
    return r;
  endfunction

  // pool keys give frequent hits and evictions; the odd fresh key misses
  function automatic cache_req_t rand_req();
    int pick;
    logic [OP_W-1:0] op;
    logic [KEY_W-1:0] key;
    pick = $urandom_range(99);
    if (pick < 40) op = OP_ADD;
    else if (pick < 75) op = OP_FIND;
    else if (pick < 95) op = OP_INVAL;
    else op = OP_UNUSED;
    if ($urandom_range(9) == 0) key = $urandom;
    else key = key_pool[$urandom_range(KEY_POOL - 1)];
    return make_req(op, key, $urandom, LENGTH_W'($urandom));
  endfunction

  task automatic drain();
    while (pend_q.size() != 0 || req_if.valid || lookup_q.size() != 0) @(posedge clk_i);
  endtask

  // driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_done) begin
      if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cache_req_t r;
        r = pend_q.pop_front();
        req_if.op <= r.op;
        req_if.key <= r.key;
        req_if.payload <= r.payload;
        req_if.length <= r.length;
        req_if.valid <= 1'b1;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off
  always @(negedge clk_i) begin
    if (long_stall_go && stall_cnt < LONG_STALL) stall_cnt <= stall_cnt + 1;
  end

  always @(negedge clk_i) begin
    rsp_if.ready <= rst_ni && !(long_stall_go && stall_cnt < LONG_STALL) &&
                    ($urandom_range(99) >= recv_idle_pct);
  end

  // request capture and prediction
  always @(posedge clk_i) begin
    req_done = req_if.valid && req_if.ready && rst_ni;
    if (req_done) begin
      lookup_q.push_back(cache_step(make_req(req_if.op, req_if.key,
                                             req_if.payload, req_if.length)));
      n_req++;
    end
  end

  // response monitor
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (lookup_q.size() == 0) begin
        flag_error("response transaction with no request outstanding");
      end else begin
        cache_rsp_t want;
        want = lookup_q.pop_front();
        check_field("found", 32'(rsp_if.found), 32'(want.found));
        check_field("evicted", 32'(rsp_if.evicted), 32'(want.evicted));
        check_field("hit_payload", rsp_if.hit_payload, want.hit_payload);
        check_field("hit_length", 32'(rsp_if.hit_length), 32'(want.hit_length));
      end
      n_rsp++;
    end
  end

  initial begin
    #TIMEOUT_NS;
    $display("timeout with %0d requests queued, %0d responses outstanding",
             pend_q.size(), lookup_q.size());
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    req_if.valid = 1'b0;
    req_if.op = OP_ADD;
    req_if.key = '0;
    req_if.payload = '0;
    req_if.length = '0;
    rsp_if.ready = 1'b0;
    for (int s = 0; s < N_SLOTS; s++) begin
      c_valid[s] = 1'b0;
      c_tag[s] = '0;
      c_pay[s] = '0;
      c_len[s] = '0;
      c_age[s] = '0;
    end
    for (int i = 0; i < KEY_POOL; i++) key_pool[i] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = '1;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // misses on an empty cache and an unused op code
    pend_q.push_back(make_req(OP_FIND, '0, $urandom, LENGTH_W'($urandom)));
    pend_q.push_back(make_req(OP_INVAL, '1, $urandom, LENGTH_W'($urandom)));
    pend_q.push_back(make_req(OP_UNUSED, '1, '1, '1));
    // fill every slot, field extremes first
    pend_q.push_back(make_req(OP_ADD, '0, '0, '0));
    pend_q.push_back(make_req(OP_ADD, '1, '1, '1));
    for (int i = 2; i < N_SLOTS; i++)
      pend_q.push_back(make_req(OP_ADD, 32'ha5a5_0000 + i, $urandom, LENGTH_W'($urandom)));
    pend_q.push_back(make_req(OP_FIND, '1, '0, '0));
    pend_q.push_back(make_req(OP_FIND, '0, '1, '1));
    // re-add of a present key, then an add into a full cache
    pend_q.push_back(make_req(OP_ADD, 32'ha5a5_0003, $urandom, LENGTH_W'($urandom)));
    pend_q.push_back(make_req(OP_ADD, 32'h5a5a_ffff, $urandom, LENGTH_W'($urandom)));
    pend_q.push_back(make_req(OP_INVAL, 32'ha5a5_0007, '0, '0));
    pend_q.push_back(make_req(OP_ADD, 32'h0f0f_0f0f, $urandom, LENGTH_W'($urandom)));
    pend_q.push_back(make_req(OP_FIND, 32'ha5a5_0007, '0, '0));

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 10; recv_idle_pct = 80; end
        1: begin send_idle_pct = 80; recv_idle_pct = 10; end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          long_stall_go = 1'b1;
        end
      endcase
      repeat (RAND_PER_PHASE) pend_q.push_back(rand_req());
      // sender pauses until every response of the phase is back
      drain();
    end

    repeat (2 * (N_SLOTS + 1) + 8) @(posedge clk_i);

    $display("%0d requests, %0d responses checked", n_req, n_rsp);
    $display("%0d evictions, %0d find hits, %0d invalidate hits, %0d mismatches",
             n_evict, n_find_hit, n_inval_hit, err_cnt);
    if (err_cnt == 0 && lookup_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- lru_age_counter_cache.f -----
rtl/lac_pkg.sv
rtl/lac_if.sv
rtl/lac_cell.sv
rtl/lru_age_counter_cache.sv
tb/tb.sv
